/* src/sms_pkg.sv */
// Shared types and constants for the SDI-12 measurement sequencer.
`default_nettype none
package sms_pkg;

    localparam int unsigned MAX_RESPONSE_LEN = 64;
    localparam int unsigned TICKS_PER_SECOND = 1000;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [7:0] ADDR_RESET    = 8'h30;
    localparam logic [3:0] MAXCMD_RESET  = 4'd8;
    localparam logic [3:0] MAXCMD_CEIL   = 4'd10;

    typedef enum logic [0:0] {
        REG_SENSOR_ADDR = 1'b0,
        REG_MAX_CMDS    = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_TICK  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        KIND_TX   = 2'd0,
        KIND_DATA = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_MEAS_RESP = 2'd1,
        PH_WAIT      = 2'd2,
        PH_DATA_RESP = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_START,
        EV_CMD,
        EV_DATA,
        EV_DONE
    } t_event;

    // Group of results from one request, drained one per cycle unless stalled.
    typedef struct packed {
        logic [2:0]      count;
        t_kind           kind;
        logic [3:0][7:0] bytes;
        logic [6:0]      expected;
        logic [7:0]      received;
    } t_burst;

endpackage
`default_nettype wire

/* src/sms_item_if.sv */
// Request channel: action and received byte.
`default_nettype none
interface sms_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface
`default_nettype wire

/* src/sms_result_if.sv */
// Result channel: transmit bytes, data bytes and completion.
`default_nettype none
interface sms_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       last;
    logic [6:0] values_expected;
    logic [7:0] values_received;

    modport source (output valid, output kind, output byte_value, output last,
                    output values_expected, output values_received, input ready);
    modport sink   (input valid, input kind, input byte_value, input last,
                    input values_expected, input values_received, output ready);
endinterface
`default_nettype wire

/* src/sms_core.sv */
// Measurement state, response parsing and result burst generation.
`default_nettype none
module sms_core
    import sms_pkg::*;
#(
    parameter int unsigned RESP_LEN_MAX  = MAX_RESPONSE_LEN,
    parameter int unsigned TICKS_PER_SEC = TICKS_PER_SECOND
)
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_go,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_rx_byte,
    output t_burst          o_burst
);

    localparam logic [19:0] TICKS_W = 20'(TICKS_PER_SEC);
    localparam logic [8:0]  RESP_LEN = 9'(RESP_LEN_MAX);

    logic [7:0]  r_addr,  n_addr;
    logic [3:0]  r_maxc,  n_maxc;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_pos,   n_pos;
    logic [9:0]  r_wait,  n_wait;
    logic [6:0]  r_exp,   n_exp;
    logic [7:0]  r_signs, n_signs;
    logic [19:0] r_ticks, n_ticks;
    logic [3:0]  r_dci,   n_dci;
    logic        r_stop,  n_stop;

    t_event      w_ev;
    logic        w_term;
    logic        w_digit;
    logic [3:0]  w_dval;
    logic        w_in_buf;
    logic        w_stop_eff;
    logic [19:0] w_prod;
    logic [19:0] w_tick_dec;
    logic [3:0]  w_dci_inc;
    logic [3:0]  w_limit;
    logic [7:0]  w_pos_inc;

    assign w_term     = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);
    assign w_digit    = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= 8'h39);
    assign w_dval     = i_rx_byte[3:0];
    assign w_in_buf   = ({1'b0, r_pos} < RESP_LEN);
    assign w_stop_eff = ((r_pos == 8'd1) || (r_pos == 8'd4)) ? 1'b0 : r_stop;
    assign w_prod     = 20'({10'd0, r_wait} * TICKS_W);
    assign w_tick_dec = (r_ticks != 20'd0) ? (r_ticks - 20'd1) : r_ticks;
    assign w_dci_inc  = r_dci + 4'd1;
    assign w_pos_inc  = (r_pos != 8'hFF) ? (r_pos + 8'd1) : r_pos;

    always_comb begin
        w_limit = r_maxc;
        if (r_maxc == 4'd0) begin
            w_limit = 4'd1;
        end else if (r_maxc > MAXCMD_CEIL) begin
            w_limit = MAXCMD_CEIL;
        end
    end

    // Next state
    always_comb begin
        n_addr  = r_addr;
        n_maxc  = r_maxc;
        n_phase = r_phase;
        n_pos   = r_pos;
        n_wait  = r_wait;
        n_exp   = r_exp;
        n_signs = r_signs;
        n_ticks = r_ticks;
        n_dci   = r_dci;
        n_stop  = r_stop;
        w_ev    = EV_NONE;

        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SENSOR_ADDR: n_addr = i_cfg_data;
                REG_MAX_CMDS:    n_maxc = i_cfg_data[3:0];
                default:         n_addr = r_addr;
            endcase
        end

        if (i_go) begin
            case (t_action'(i_action))
                ACT_START: begin
                    n_pos   = 8'd0;
                    n_wait  = 10'd0;
                    n_exp   = 7'd0;
                    n_signs = 8'd0;
                    n_ticks = 20'd0;
                    n_dci   = 4'd0;
                    n_stop  = 1'b0;
                    n_phase = PH_MEAS_RESP;
                    w_ev    = EV_START;
                end
                ACT_BYTE: begin
                    case (r_phase)
                        PH_MEAS_RESP: begin
                            if (w_term) begin
                                n_ticks = w_prod;
                                if (w_prod == 20'd0) begin
                                    n_pos   = 8'd0;
                                    n_phase = PH_DATA_RESP;
                                    w_ev    = EV_CMD;
                                end else begin
                                    n_phase = PH_WAIT;
                                end
                            end else if (w_in_buf) begin
                                n_stop = w_stop_eff;
                                if (r_pos >= 8'd1 && r_pos <= 8'd3) begin
                                    if (!w_stop_eff && w_digit) begin
                                        n_wait = 10'(r_wait * 10'd10) + {6'd0, w_dval};
                                    end else begin
                                        n_stop = 1'b1;
                                    end
                                end else if (r_pos >= 8'd4 && r_pos <= 8'd5) begin
                                    if (!w_stop_eff && w_digit) begin
                                        n_exp = 7'(r_exp * 7'd10) + {3'd0, w_dval};
                                    end else begin
                                        n_stop = 1'b1;
                                    end
                                end
                                n_pos = w_pos_inc;
                            end
                        end
                        PH_DATA_RESP: begin
                            if (w_term) begin
                                n_dci = w_dci_inc;
                                if ((r_signs >= {1'b0, r_exp}) || (w_dci_inc >= w_limit)) begin
                                    n_phase = PH_IDLE;
                                    w_ev    = EV_DONE;
                                end else begin
                                    n_pos = 8'd0;
                                    w_ev  = EV_CMD;
                                end
                            end else if (w_in_buf) begin
                                if ((i_rx_byte == CH_PLUS || i_rx_byte == CH_MINUS)
                                        && r_signs != 8'hFF) begin
                                    n_signs = r_signs + 8'd1;
                                end
                                n_pos = w_pos_inc;
                                if (r_pos != 8'd0) begin
                                    w_ev = EV_DATA;
                                end
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                ACT_TICK: begin
                    if (r_phase == PH_WAIT) begin
                        n_ticks = w_tick_dec;
                        if (w_tick_dec == 20'd0) begin
                            n_pos   = 8'd0;
                            n_phase = PH_DATA_RESP;
                            w_ev    = EV_CMD;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Burst outputs
    always_comb begin
        o_burst          = '0;
        o_burst.kind     = KIND_TX;
        o_burst.expected = n_exp;
        o_burst.received = n_signs;
        case (w_ev)
            EV_START: begin
                o_burst.count = 3'd3;
                o_burst.bytes = {8'd0, CH_BANG, CH_C, r_addr};
            end
            EV_CMD: begin
                o_burst.count = 3'd4;
                o_burst.bytes = {CH_BANG, CH_ZERO + {4'd0, n_dci}, CH_D, r_addr};
            end
            EV_DATA: begin
                o_burst.count = 3'd1;
                o_burst.kind  = KIND_DATA;
                o_burst.bytes = {24'd0, i_rx_byte};
            end
            EV_DONE: begin
                o_burst.count = 3'd1;
                o_burst.kind  = KIND_DONE;
            end
            default: begin
                o_burst.count = 3'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= ADDR_RESET;
            r_maxc  <= MAXCMD_RESET;
            r_phase <= PH_IDLE;
            r_pos   <= 8'd0;
            r_wait  <= 10'd0;
            r_exp   <= 7'd0;
            r_signs <= 8'd0;
            r_ticks <= 20'd0;
            r_dci   <= 4'd0;
            r_stop  <= 1'b0;
        end else begin
            r_addr  <= n_addr;
            r_maxc  <= n_maxc;
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_wait  <= n_wait;
            r_exp   <= n_exp;
            r_signs <= n_signs;
            r_ticks <= n_ticks;
            r_dci   <= n_dci;
            r_stop  <= n_stop;
        end
    end

endmodule
`default_nettype wire

/* src/sdi12_measurement_sequencer.sv */
// SDI-12 measurement sequencer: one start-measurement / send-data exchange.
//
// Requests arrive on i_in (action: start, received bus byte, millisecond tick).
// Results leave on o_out: command bytes to transmit, data bytes forwarded from
// the sensor, and a completion marker; last flags the final result of a request.
// The user writes sensor address and data command limit via i_cfg_* only while
// idle; the block itself does not enforce this.
// A request is taken into an input register, processed once the burst register
// is free or its last result is being taken, and its results are loaded into
// the burst register. A request yields zero to four results, drained one per
// cycle while the receiver is ready, so the rate is one request per cycle for
// requests with at most one result; a request with more results holds back the
// next request until its last result is taken.
// A new request is accepted while the previous burst is still being delivered.
// When the receiver stalls, the burst holds and the input register fills, then
// ready drops. Synchronous reset empties both registers, returns the sequencer
// to idle and restores address '0' and a limit of eight data commands.
`default_nettype none
module sdi12_measurement_sequencer
    import sms_pkg::*;
#(
    parameter int unsigned RESP_LEN_MAX  = MAX_RESPONSE_LEN,
    parameter int unsigned TICKS_PER_SEC = TICKS_PER_SECOND
)
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    sms_item_if.sink        i_in,
    sms_result_if.source    o_out
);

    logic       r_in_vld;
    logic [1:0] r_in_action;
    logic [7:0] r_in_byte;
    t_burst     r_bst;
    logic       r_ovld;
    logic [1:0] r_idx;

    t_burst     w_burst;
    logic       w_last;
    logic       w_take;
    logic       w_proc;
    logic       w_accept;

    assign w_last   = ({1'b0, r_idx} == (r_bst.count - 3'd1));
    assign w_take   = r_ovld && o_out.ready;
    assign w_proc   = r_in_vld && (!r_ovld || (w_take && w_last));
    assign w_accept = i_in.valid && i_in.ready;

    assign i_in.ready = !r_in_vld || w_proc;

    sms_core #(
        .RESP_LEN_MAX  (RESP_LEN_MAX),
        .TICKS_PER_SEC (TICKS_PER_SEC)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_go       (w_proc),
        .i_action   (r_in_action),
        .i_rx_byte  (r_in_byte),
        .o_burst    (w_burst)
    );

    assign o_out.valid           = r_ovld;
    assign o_out.kind            = r_bst.kind;
    assign o_out.byte_value      = r_bst.bytes[r_idx];
    assign o_out.last            = w_last;
    assign o_out.values_expected = r_bst.expected;
    assign o_out.values_received = r_bst.received;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_action <= i_in.action;
            r_in_byte   <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_idx  <= 2'd0;
        end else if (w_proc && w_burst.count != 3'd0) begin
            r_ovld <= 1'b1;
            r_idx  <= 2'd0;
        end else if (w_take) begin
            if (w_last) begin
                r_ovld <= 1'b0;
                r_idx  <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Load the payload of a new burst.
    always_ff @(posedge i_clk) begin
        if (w_proc && w_burst.count != 3'd0) begin
            r_bst <= w_burst;
        end
    end

    a_idx_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> ({1'b0, r_idx} < r_bst.count))
        else $error("burst index past burst length");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_bst.kind == KIND_DONE) |-> (r_bst.count == 3'd1 && o_out.last
            && o_out.byte_value == 8'd0))
        else $error("completion not a single zero result");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_ovld && !o_out.ready) |=> (r_in_vld && $stable(r_in_action)
            && $stable(r_in_byte)))
        else $error("pending request lost during output stall");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> i_in.ready)
        else $error("input not ready with empty input register");

endmodule
`default_nettype wire
